/* sv/aelb_pkg.sv */
// Shared types, codes and constants for the aging error log buffer.
`default_nettype none

package aelb_pkg;

  // Default number of record slots
  localparam int DEPTH_DEF = 16;

  // Operation codes carried in the input mode field
  localparam logic [2:0] MODE_INIT  = 3'd0;
  localparam logic [2:0] MODE_ADD   = 3'd1;
  localparam logic [2:0] MODE_TICK  = 3'd2;
  localparam logic [2:0] MODE_CLEAR = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_AGE   = 2'd0;
  localparam logic [1:0] CFG_NEW_AGE   = 2'd1;
  localparam logic [1:0] CFG_EMPTY_AGE = 2'd2;

  // Configuration reset values
  localparam logic [15:0] MAX_AGE_RST   = 16'd15;
  localparam logic [15:0] NEW_AGE_RST   = 16'd0;
  localparam logic [15:0] EMPTY_AGE_RST = 16'hFFFF;

  // Stream payload widths (tdata in whole bytes)
  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_TUSER_W = 2;

  // One stored record, age in the low bits
  typedef struct packed {
    logic [7:0]  func;
    logic [7:0]  unit;
    logic [31:0] code;
    logic [15:0] age;
  } rec_t;

  // Configuration register file contents
  typedef struct packed {
    logic [15:0] max_age;
    logic [15:0] new_age;
    logic [15:0] empty_age;
  } cfg_t;

endpackage

`default_nettype wire

/* sv/aelb_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none

module aelb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/aelb_cfg.sv */
// Configuration register file: max, new and empty record ages.
`default_nettype none

module aelb_cfg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire logic [1:0]    wr_index,
  input  wire logic [15:0]   wr_data,
  output aelb_pkg::cfg_t     cfg
);

  import aelb_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // Register decode; an index past the list is dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_MAX_AGE:   cfg_nxt.max_age   = wr_data;
        CFG_NEW_AGE:   cfg_nxt.new_age   = wr_data;
        CFG_EMPTY_AGE: cfg_nxt.empty_age = wr_data;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_age   <= MAX_AGE_RST;
      cfg_r.new_age   <= NEW_AGE_RST;
      cfg_r.empty_age <= EMPTY_AGE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* sv/aging_error_log_buffer.sv */
// Aging error log buffer: ring of error records kept in one RAM, read-modify-write sequencer.
//
//  channel | ports             | dir | payload
//  --------+-------------------+-----+---------------------------------------------
//  in      | in_tvalid/tready  | in  | tdata: error, unit, function, read index
//          |                   |     | tuser: mode
//  out     | out_tvalid/tready | out | tdata: record fields, count, next slot
//          |                   |     | tuser: status, duplicate flag
//  cfg     | cfg_valid/ready   | in  | cfg_index, cfg_data (always ready)
//
// One item at a time. Add, tick and clear sweep the record RAM once through its single read
// port and write back each slot in the cycle after its read, then load the result register.
// Init writes every slot; read fetches one slot, and other modes go straight to the result.
// After reset a clearing pass fills the RAM before the first item is taken.
// A result waiting on out_tready holds the sequencer in its last step; in_tready is low
// while an item is in work.
`default_nettype none

module aging_error_log_buffer #(
  parameter int DEPTH = aelb_pkg::DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // in_tdata: [31:0] error_code, [39:32] unit_code, [47:40] function_code,
  //           [51:48] read_index, [55:52] zero
  input  wire logic [aelb_pkg::IN_TDATA_W-1:0] in_tdata,
  // in_tuser: [2:0] mode
  input  wire logic [aelb_pkg::IN_TUSER_W-1:0] in_tuser,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // out_tdata: [15:0] rec_age, [47:16] rec_error, [55:48] rec_unit,
  //            [63:56] rec_function, [68:64] record_count, [72:69] next_slot,
  //            [79:73] zero
  output logic [aelb_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // out_tuser: [0] status, [1] was_duplicate
  output logic [aelb_pkg::OUT_TUSER_W-1:0]     out_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [15:0]                     cfg_data
);

  import aelb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // Sequencer states
  localparam logic [2:0] S_FILL = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_RDD  = 3'd4;
  localparam logic [2:0] S_PUSH = 3'd5;

  cfg_t cfg;

  // Configuration registers
  assign cfg_ready = 1'b1;

  aelb_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Record RAM
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  rec_t          ram_wdata, ram_rdata;

  aelb_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer and log state
  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_idx_r, pend_idx_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [31:0]   code_r, code_nxt;
  logic [7:0]    unit_r, unit_nxt;
  logic [7:0]    func_r, func_nxt;
  logic [3:0]    ridx_r, ridx_nxt;
  logic          found_r, found_nxt;
  logic [CW-1:0] tally_r, tally_nxt;
  logic [15:0]   fill_age_r, fill_age_nxt;
  logic          fill_init_r, fill_init_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic          res_status_r, res_status_nxt;
  logic          res_dup_r, res_dup_nxt;
  rec_t          res_rec_r, res_rec_nxt;

  // Output register
  logic          out_valid_r, out_valid_nxt;
  logic          out_status_r, out_status_nxt;
  logic          out_dup_r, out_dup_nxt;
  rec_t          out_rec_r, out_rec_nxt;
  logic [4:0]    out_count_r, out_count_nxt;
  logic [3:0]    out_slot_r, out_slot_nxt;

  logic          in_xfer, scan_last, rec_match, rd_in_range;
  logic [2:0]    in_mode;
  logic [31:0]   in_code;
  logic [7:0]    in_unit, in_func;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid & in_tready;
  assign in_mode   = in_tuser[2:0];
  assign in_code   = in_tdata[31:0];
  assign in_unit   = in_tdata[39:32];
  assign in_func   = in_tdata[47:40];
  assign scan_last = (cnt_r == CW'(DEPTH));
  assign rec_match = (ram_rdata.code == code_r) && (ram_rdata.unit == unit_r) &&
                     (ram_rdata.func == func_r) && (ram_rdata.age == cfg.new_age);
  assign rd_in_range = (32'(ridx_r) < DEPTH);

  // Next-state logic
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    op_nxt         = op_r;
    code_nxt       = code_r;
    unit_nxt       = unit_r;
    func_nxt       = func_r;
    ridx_nxt       = ridx_r;
    found_nxt      = found_r;
    tally_nxt      = tally_r;
    fill_age_nxt   = fill_age_r;
    fill_init_nxt  = fill_init_r;
    slot_nxt       = slot_r;
    held_nxt       = held_r;
    res_status_nxt = res_status_r;
    res_dup_nxt    = res_dup_r;
    res_rec_nxt    = res_rec_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_status_nxt = out_status_r;
    out_dup_nxt    = out_dup_r;
    out_rec_nxt    = out_rec_r;
    out_count_nxt  = out_count_r;
    out_slot_nxt   = out_slot_r;
    ram_we         = 1'b0;
    ram_waddr      = pend_idx_r;
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = cnt_r[AW-1:0];

    unique case (state_r)
      // Write an empty record into every slot
      S_FILL: begin
        ram_we         = 1'b1;
        ram_waddr      = cnt_r[AW-1:0];
        ram_wdata      = '0;
        ram_wdata.age  = fill_age_r;
        cnt_nxt        = cnt_r + 1'b1;
        if (cnt_r == CW'(DEPTH - 1)) begin
          slot_nxt  = '0;
          held_nxt  = '0;
          state_nxt = fill_init_r ? S_PUSH : S_IDLE;
        end
      end

      // Take an item and dispatch on its mode
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt         = in_mode;
          code_nxt       = in_code;
          unit_nxt       = in_unit;
          func_nxt       = in_func;
          ridx_nxt       = in_tdata[51:48];
          cnt_nxt        = '0;
          pend_nxt       = 1'b0;
          found_nxt      = 1'b0;
          tally_nxt      = '0;
          res_status_nxt = 1'b0;
          res_dup_nxt    = 1'b0;
          res_rec_nxt    = '0;
          unique case (in_mode)
            MODE_INIT: begin
              fill_age_nxt  = cfg.empty_age;
              fill_init_nxt = 1'b1;
              state_nxt     = S_FILL;
            end
            MODE_ADD: begin
              if (in_code == '0 || in_unit == '0 || in_func == '0) begin
                res_status_nxt = 1'b1;
                state_nxt      = S_PUSH;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            MODE_TICK, MODE_CLEAR: state_nxt = S_SCAN;
            MODE_READ:             state_nxt = S_RD;
            default:               state_nxt = S_PUSH;
          endcase
        end
      end

      // Sweep: read slot cnt, modify and write back the slot read last cycle
      S_SCAN: begin
        if (!scan_last) begin
          ram_re  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
        pend_nxt     = !scan_last;
        pend_idx_nxt = cnt_r[AW-1:0];
        if (pend_r) begin
          priority case (op_r)
            MODE_TICK: begin
              if (ram_rdata.age < cfg.max_age) begin
                ram_we        = 1'b1;
                ram_wdata.age = ram_rdata.age + 16'd1;
              end
            end
            MODE_CLEAR: begin
              if (ram_rdata.age < cfg.max_age) begin
                tally_nxt = tally_r + 1'b1;
              end else if (ram_rdata.age == cfg.max_age) begin
                ram_we        = 1'b1;
                ram_wdata     = '0;
                ram_wdata.age = cfg.empty_age;
              end
            end
            MODE_ADD: begin
              found_nxt = found_r | rec_match;
            end
            default: ;
          endcase
        end
        if (scan_last) begin
          state_nxt = S_PUSH;
          priority case (op_r)
            MODE_CLEAR: begin
              held_nxt = tally_nxt;
              if (tally_nxt == '0) begin
                slot_nxt = '0;
              end
            end
            MODE_ADD: begin
              if (found_nxt) begin
                res_dup_nxt = 1'b1;
              end else begin
                ram_we         = 1'b1;
                ram_waddr      = slot_r;
                ram_wdata.age  = cfg.new_age;
                ram_wdata.code = code_r;
                ram_wdata.unit = unit_r;
                ram_wdata.func = func_r;
                if (held_r < CW'(DEPTH)) begin
                  held_nxt = held_r + 1'b1;
                end
                slot_nxt = (slot_r == AW'(DEPTH - 1)) ? '0 : slot_r + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      // Single record read
      S_RD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(ridx_r);
        state_nxt = S_RDD;
      end

      S_RDD: begin
        if (rd_in_range) begin
          res_rec_nxt = ram_rdata;
        end
        state_nxt = S_PUSH;
      end

      // Hand the result to the output register once it is free
      S_PUSH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_dup_nxt    = res_dup_r;
          out_rec_nxt    = res_rec_r;
          out_count_nxt  = 5'(held_r);
          out_slot_nxt   = 4'(slot_r);
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      fill_age_r  <= EMPTY_AGE_RST;
      fill_init_r <= 1'b0;
      slot_r      <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      fill_age_r  <= fill_age_nxt;
      fill_init_r <= fill_init_nxt;
      slot_r      <= slot_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_idx_r   <= pend_idx_nxt;
    op_r         <= op_nxt;
    code_r       <= code_nxt;
    unit_r       <= unit_nxt;
    func_r       <= func_nxt;
    ridx_r       <= ridx_nxt;
    found_r      <= found_nxt;
    tally_r      <= tally_nxt;
    res_status_r <= res_status_nxt;
    res_dup_r    <= res_dup_nxt;
    res_rec_r    <= res_rec_nxt;
    out_status_r <= out_status_nxt;
    out_dup_r    <= out_dup_nxt;
    out_rec_r    <= out_rec_nxt;
    out_count_r  <= out_count_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  // Output packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_dup_r, out_status_r};
  assign out_tdata  = {7'd0, out_slot_r, out_count_r, out_rec_r};

`ifndef SYNTHESIS
  // The write-back trails the read, so one slot is never read and written together
  a_no_rw_same_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("record RAM read and written at the same slot");

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(DEPTH))
    else $error("record count above ring depth");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken before the first finished");

  a_push_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH) && (!out_valid_r || out_tready) |=> out_valid_r)
    else $error("finished result not presented");
`endif

endmodule

`default_nettype wire
